>>> hw/rtl/ist_pkg.sv
// ----------------------------------------------------------------------------
// ist_pkg
// Request/response types and operation codes for the interval set tracker.
// ----------------------------------------------------------------------------
package ist_pkg;

  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_QUERY  = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] span_start;
    logic [31:0] span_end;
  } req_t;

  typedef struct packed {
    logic covered;
    logic table_full;
  } rsp_t;

endpackage

>>> hw/rtl/ist_ram.sv
// ----------------------------------------------------------------------------
// ist_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ist_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/interval_set_tracker.sv
// ----------------------------------------------------------------------------
// interval_set_tracker
// Sorted table of disjoint half-open intervals with add, remove and query.
// ----------------------------------------------------------------------------
// Usage: raise start with a request while busy is low; the request is taken at
// that edge. Exactly one response follows, shown on rsp for a single cycle
// with done high; it cannot be held off, so capture it then. busy is already
// low in the done cycle, so the next request may be issued there. The search
// reads table entries in order, a read state and an evaluate state for each
// (up to and including the first entry past the span); the end-of-table check,
// planning and write-back follow, with a read state and a write state for each
// entry shifted to open or close a gap. The registered read data of the table
// RAM is why each read has a state of its own. Empty spans and the unused mode
// answer at once and never raise busy; other requests raise busy at the accept.
// No clearing pass is needed after reset: only entries below the count are
// ever read.
// ----------------------------------------------------------------------------
module interval_set_tracker #(
  parameter int MAX_INTERVALS = 64,
  parameter int COORD_WIDTH   = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  ist_pkg::req_t req,
  output logic          done,
  output ist_pkg::rsp_t rsp
);

  import ist_pkg::*;

  localparam int IW = $clog2(MAX_INTERVALS);
  localparam int NW = $clog2(MAX_INTERVALS + 1);
  localparam int CW = COORD_WIDTH;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SC_RD = 4'd1;
  localparam logic [3:0] S_SC_EV = 4'd2;
  localparam logic [3:0] S_PLAN  = 4'd3;
  localparam logic [3:0] S_MV_RD = 4'd4;
  localparam logic [3:0] S_MV_WR = 4'd5;
  localparam logic [3:0] S_WR0   = 4'd6;
  localparam logic [3:0] S_WR1   = 4'd7;

  logic [3:0]    state;
  logic [NW-1:0] count;       // valid entries
  logic [1:0]    op;
  logic [CW-1:0] lo, hi;

  // search results
  logic [NW-1:0] scan_idx;
  logic          found;
  logic [NW-1:0] first_idx;   // i: first entry reaching the span
  logic [NW-1:0] incl_cnt;    // m: entries overlapping the span (touching too, except on remove)
  logic [CW-1:0] first_start;
  logic [CW-1:0] last_end;

  // write-back plan
  logic [1:0]    npieces;
  logic [CW-1:0] p0_s, p0_e, p1_s, p1_e;
  logic [NW-1:0] mv_src, mv_dst, mv_left;
  logic          mv_down;

  // table RAM: {start, end}
  logic            ram_we;
  logic [IW-1:0]   ram_waddr, ram_raddr;
  logic [2*CW-1:0] ram_wdata, ram_rdata;

  ist_ram #(.WIDTH(2 * CW), .DEPTH(MAX_INTERVALS)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  logic [CW-1:0] rd_s, rd_e;
  logic          is_rem, reach, scond;
  assign rd_s   = ram_rdata[2*CW-1:CW];
  assign rd_e   = ram_rdata[CW-1:0];
  assign is_rem = (op == MODE_REMOVE);
  // remove searches with strict compares: a merely touching entry is untouched
  assign reach  = is_rem ? (rd_e > lo) : (rd_e >= lo);
  assign scond  = is_rem ? (rd_s < hi) : (rd_s <= hi);

  // plan terms, valid in S_PLAN
  logic [NW-1:0] j_idx;
  logic          lp, rp, has_m;
  logic [1:0]    k_pl;
  logic [NW:0]   newcnt;
  logic [NW-1:0] dst0, nmove;
  assign j_idx  = first_idx + incl_cnt;
  assign has_m  = (incl_cnt != '0);
  assign lp     = has_m && (first_start < lo);
  assign rp     = has_m && (last_end > hi);
  assign k_pl   = is_rem ? ({1'b0, lp} + {1'b0, rp}) : 2'd1;
  assign newcnt = {1'b0, count} - {1'b0, incl_cnt} + (NW + 1)'(k_pl);
  assign dst0   = first_idx + NW'(k_pl);
  assign nmove  = count - j_idx;

  assign busy = (state != S_IDLE);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = ram_rdata;
    ram_raddr = '0;
    unique case (state)
      S_SC_RD: ram_raddr = scan_idx[IW-1:0];
      S_MV_RD: ram_raddr = mv_src[IW-1:0];
      S_MV_WR: begin
        ram_we    = 1'b1;
        ram_waddr = mv_dst[IW-1:0];
        ram_wdata = ram_rdata;
      end
      S_WR0: begin
        ram_we    = 1'b1;
        ram_waddr = first_idx[IW-1:0];
        ram_wdata = {p0_s, p0_e};
      end
      S_WR1: begin
        ram_we    = 1'b1;
        ram_waddr = IW'(first_idx + NW'(1));
        ram_wdata = {p1_s, p1_e};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op          <= req.mode;
            lo          <= CW'(req.span_start);
            hi          <= CW'(req.span_end);
            scan_idx    <= '0;
            found       <= 1'b0;
            incl_cnt    <= '0;
            rsp         <= '0;
            // empty span or unused mode: answer at once
            if ((CW'(req.span_start) >= CW'(req.span_end)) ||
                (req.mode != MODE_ADD && req.mode != MODE_REMOVE &&
                 req.mode != MODE_QUERY)) begin
              done <= 1'b1;
            end else begin
              state <= S_SC_RD;
            end
          end
        end
        S_SC_RD: begin
          if (scan_idx == count) begin
            if (!found) first_idx <= scan_idx;
            if (op == MODE_QUERY) begin
              done  <= 1'b1;
              state <= S_IDLE;
            end else begin
              state <= S_PLAN;
            end
          end else begin
            state <= S_SC_EV;
          end
        end
        S_SC_EV: begin
          if (!found && !reach) begin
            scan_idx <= scan_idx + NW'(1);
            state    <= S_SC_RD;
          end else if (op == MODE_QUERY) begin
            rsp.covered <= (rd_s <= lo) && (rd_e >= hi);
            done        <= 1'b1;
            state       <= S_IDLE;
          end else begin
            if (!found) first_idx <= scan_idx;
            found <= 1'b1;
            if (scond) begin
              if (incl_cnt == '0) first_start <= rd_s;
              last_end <= rd_e;
              incl_cnt <= incl_cnt + NW'(1);
              scan_idx <= scan_idx + NW'(1);
              state    <= S_SC_RD;
            end else begin
              state <= S_PLAN;
            end
          end
        end
        S_PLAN: begin
          npieces <= k_pl;
          if (is_rem) begin
            p0_s <= lp ? first_start : hi;
            p0_e <= lp ? lo : last_end;
          end else begin
            p0_s <= lp ? first_start : lo;
            p0_e <= rp ? last_end : hi;
          end
          p1_s <= hi;
          p1_e <= last_end;
          if (is_rem && !has_m) begin
            done  <= 1'b1;        // nothing tracked in the span
            state <= S_IDLE;
          end else if (newcnt > (NW + 1)'(MAX_INTERVALS)) begin
            rsp.table_full <= 1'b1;
            done           <= 1'b1;
            state          <= S_IDLE;
          end else begin
            count   <= newcnt[NW-1:0];
            mv_left <= nmove;
            if (nmove == '0 || dst0 == j_idx) begin
              if (k_pl == 2'd0) begin
                done  <= 1'b1;
                state <= S_IDLE;
              end else begin
                state <= S_WR0;
              end
            end else if (dst0 > j_idx) begin
              // open a gap: copy top-down
              mv_down <= 1'b1;
              mv_src  <= count - NW'(1);
              mv_dst  <= count;
              state   <= S_MV_RD;
            end else begin
              // close a gap: copy bottom-up
              mv_down <= 1'b0;
              mv_src  <= j_idx;
              mv_dst  <= dst0;
              state   <= S_MV_RD;
            end
          end
        end
        S_MV_RD: state <= S_MV_WR;
        S_MV_WR: begin
          mv_left <= mv_left - NW'(1);
          mv_src  <= mv_down ? mv_src - NW'(1) : mv_src + NW'(1);
          mv_dst  <= mv_down ? mv_dst - NW'(1) : mv_dst + NW'(1);
          if (mv_left == NW'(1)) begin
            if (npieces == 2'd0) begin
              done  <= 1'b1;
              state <= S_IDLE;
            end else begin
              state <= S_WR0;
            end
          end else begin
            state <= S_MV_RD;
          end
        end
        S_WR0: begin
          if (npieces == 2'd2) begin
            state <= S_WR1;
          end else begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_WR1: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a response only ever closes a request, and the table never overflows
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done while busy");
  a_rsp_excl: assert property (@(posedge clk) disable iff (rst)
      done |-> !(rsp.covered && rsp.table_full))
    else $error("covered and table_full together");
  a_count_max: assert property (@(posedge clk) disable iff (rst)
      count <= NW'(MAX_INTERVALS))
    else $error("interval count above table size");
  a_accept: assert property (@(posedge clk) disable iff (rst)
      (start && !busy) |=> (busy || done))
    else $error("request accepted without work or response");
  a_count_hold: assert property (@(posedge clk) disable iff (rst)
      (!busy && !$past(busy)) |-> $stable(count))
    else $error("count changed while idle");

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the interval set tracker against a behavioral copy of its interval
// table. Add, remove and query requests are driven with random start gaps;
// every response is compared with the predicted covered and table_full bits.
// ----------------------------------------------------------------------------
module tb_top;
  import ist_pkg::*;

  localparam int MAX_IV    = 64;
  localparam int LIMIT_CYC = 1000000;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  start = 1'b0;
  logic  busy;
  logic  done;
  req_t  req = '0;
  rsp_t  rsp;

  // model of the stored interval table
  logic [31:0] iv_lo [MAX_IV+2];
  logic [31:0] iv_hi [MAX_IV+2];
  int          iv_cnt;

  rsp_t        expected_rsp_q[$];
  int          mismatch_cnt = 0;
  int          unexpected_cnt = 0;
  int          rsp_cnt = 0;
  int          full_cnt = 0;
  int          covered_cnt = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  int cyc = 0;
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= LIMIT_CYC) begin
      $display("Timeout after %0d cycles", cyc);
      $display("Simulation FAILED");
      $finish;
    end
  end

  interval_set_tracker #(.MAX_INTERVALS(MAX_IV), .COORD_WIDTH(32)) i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req), .done(done), .rsp(rsp)
  );

  // response checker: done marks a one-cycle response, compared with oldest
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && done) begin
      rsp_cnt <= rsp_cnt + 1;
      if (expected_rsp_q.size() == 0) begin
        unexpected_cnt <= unexpected_cnt + 1;
        $display("Unexpected response %b", rsp);
      end else begin
        want = expected_rsp_q.pop_front();
        if (rsp !== want) begin
          if (mismatch_cnt < 10)
            $display("Mismatch at cycle %0d: exp covered=%b full=%b, got covered=%b full=%b",
                     cyc, want.covered, want.table_full, rsp.covered, rsp.table_full);
          mismatch_cnt <= mismatch_cnt + 1;
        end
      end
    end
  end

  // shift entries [src, iv_cnt) to start at dst
  function automatic void shift_entries(input int dst, input int src);
    int n;
    n = iv_cnt - src;
    if (dst > src) begin
      for (int k = n - 1; k >= 0; k--) begin
        iv_lo[dst+k] = iv_lo[src+k];
        iv_hi[dst+k] = iv_hi[src+k];
      end
    end else begin
      for (int k = 0; k < n; k++) begin
        iv_lo[dst+k] = iv_lo[src+k];
        iv_hi[dst+k] = iv_hi[src+k];
      end
    end
  endfunction

  // applies one request to the model table and returns the response
  function automatic rsp_t apply_to_table(input req_t r);
    rsp_t        res;
    int          i, j, m, pc, new_cnt;
    logic [31:0] lo, hi, ns, ne;
    logic [31:0] pl[2], ph[2];
    res = '0;
    lo = r.span_start;
    hi = r.span_end;
    if (lo >= hi) return res;
    case (r.mode)
      MODE_ADD: begin
        i = 0;
        while (i < iv_cnt && iv_hi[i] < lo) i++;
        j = i; ns = lo; ne = hi;
        while (j < iv_cnt && iv_lo[j] <= hi) begin
          if (iv_lo[j] < ns) ns = iv_lo[j];
          if (iv_hi[j] > ne) ne = iv_hi[j];
          j++;
        end
        m = j - i;
        if (m == 0) begin
          if (iv_cnt >= MAX_IV) begin
            res.table_full = 1'b1;
          end else begin
            shift_entries(i + 1, i);
            iv_lo[i] = ns; iv_hi[i] = ne;
            iv_cnt++;
          end
        end else begin
          iv_lo[i] = ns; iv_hi[i] = ne;
          if (m > 1) begin
            shift_entries(i + 1, j);
            iv_cnt -= m - 1;
          end
        end
      end
      MODE_REMOVE: begin
        i = 0;
        while (i < iv_cnt && iv_hi[i] <= lo) i++;
        j = i;
        while (j < iv_cnt && iv_lo[j] < hi) j++;
        m = j - i;
        if (m != 0) begin
          pc = 0;
          if (iv_lo[i] < lo) begin
            pl[pc] = iv_lo[i]; ph[pc] = lo; pc++;
          end
          if (iv_hi[j-1] > hi) begin
            pl[pc] = hi; ph[pc] = iv_hi[j-1]; pc++;
          end
          new_cnt = iv_cnt - m + pc;
          if (new_cnt > MAX_IV) begin
            res.table_full = 1'b1;
          end else begin
            shift_entries(i + pc, j);
            for (int k = 0; k < pc; k++) begin
              iv_lo[i+k] = pl[k]; iv_hi[i+k] = ph[k];
            end
            iv_cnt = new_cnt;
          end
        end
      end
      MODE_QUERY: begin
        i = 0;
        while (i < iv_cnt && iv_hi[i] < lo) i++;
        if (i < iv_cnt) res.covered = (iv_lo[i] <= lo) && (iv_hi[i] >= hi);
      end
      default: ;
    endcase
    return res;
  endfunction

  bit idle_gaps = 1'b1;

  // sends one request, with an optional random hold-off burst first;
  // start stays high after the accept so requests can follow back to back
  task automatic send_request(input logic [1:0] mode, input logic [31:0] lo,
                              input logic [31:0] hi);
    req_t r;
    rsp_t p;
    r.mode = mode; r.span_start = lo; r.span_end = hi;
    if (idle_gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
    p = apply_to_table(r);
    if (p.table_full) full_cnt++;
    if (p.covered) covered_cnt++;
    expected_rsp_q = {expected_rsp_q, p};
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_request(MODE_QUERY, 32'd0, 32'd10);
    send_request(MODE_REMOVE, 32'd0, 32'd10);
    send_request(MODE_ADD, 32'd10, 32'd10);
    send_request(MODE_ADD, 32'd20, 32'd10);
    send_request(MODE_UNUSED, 32'd0, 32'd100);
    send_request(MODE_ADD, 32'd0, 32'd1);
    send_request(MODE_ADD, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
    send_request(MODE_ADD, 32'd10, 32'd20);
    send_request(MODE_ADD, 32'd20, 32'd30);   // touching merge
    send_request(MODE_QUERY, 32'd10, 32'd30);
    send_request(MODE_QUERY, 32'd9, 32'd30);
    send_request(MODE_REMOVE, 32'd15, 32'd18); // split
    send_request(MODE_QUERY, 32'd10, 32'd30);
    send_request(MODE_ADD, 32'd0, 32'hFFFF_FFFF); // merge everything
    send_request(MODE_QUERY, 32'h5555_5555, 32'hAAAA_AAAA);
    send_request(MODE_REMOVE, 32'd0, 32'hFFFF_FFFF);
    send_request(MODE_QUERY, 32'd0, 32'd1);
  endtask

  // fills the table to capacity, then tries new adds, a splitting remove and a trim
  task automatic test_full_table();
    wait_drained();
    for (int k = 0; k < MAX_IV; k++)
      send_request(MODE_ADD, 32'(k * 100), 32'(k * 100 + 50));
    send_request(MODE_ADD, 32'd70, 32'd80);          // refused
    send_request(MODE_REMOVE, 32'd110, 32'd120);     // split refused
    send_request(MODE_REMOVE, 32'd100, 32'd120);     // trims, allowed
    send_request(MODE_ADD, 32'd60, 32'd100);         // touches nothing, refused
    send_request(MODE_QUERY, 32'd0, 32'd50);
    send_request(MODE_REMOVE, 32'd0, 32'hFFFF_FFFF);
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 1000);
      1:       return $urandom();
      2:       return 32'hFFFF_FFFF - $urandom_range(0, 200);
      default: return $urandom_range(0, 4000);
    endcase
  endfunction

  task automatic test_random(input int n);
    logic [31:0] a, b, w;
    logic [1:0]  mode;
    for (int k = 0; k < n; k++) begin
      a = pick_coord();
      w = $urandom_range(0, 9) == 0 ? $urandom() : $urandom_range(1, 120);
      b = ($urandom_range(0, 19) == 0) ? pick_coord() : a + w;
      if (b < a && $urandom_range(0, 3) != 0) b = 32'hFFFF_FFFF;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: mode = MODE_ADD;
        4, 5:       mode = MODE_REMOVE;
        9:          mode = ($urandom_range(0, 3) == 0) ? MODE_UNUSED : MODE_QUERY;
        default:    mode = MODE_QUERY;
      endcase
      send_request(mode, a, b);
      if (k == n / 2) wait_drained();
    end
  endtask

  initial begin
    iv_cnt = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_table();
    test_random(620);
    idle_gaps = 1'b0;
    test_random(100);
    wait_drained();
    repeat (300) @(posedge clk);
    $display("Ran %0d responses: %0d table-full refusals, %0d covered queries",
             rsp_cnt, full_cnt, covered_cnt);
    $display("Table held %0d intervals at end", iv_cnt);
    if (mismatch_cnt == 0 && unexpected_cnt == 0 && expected_rsp_q.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> interval_set_tracker.f
hw/rtl/ist_pkg.sv
hw/rtl/ist_ram.sv
hw/rtl/interval_set_tracker.sv
tb/sv/tb_top.sv
